[rtl/qpe_pkg.sv]
`default_nettype none

package qpe_pkg;

  // Configuration register indexes.
  localparam logic [2:0] REG_NAME_LEN  = 3'd0;
  localparam logic [2:0] REG_NAME_LO   = 3'd1;
  localparam logic [2:0] REG_NAME_MID  = 3'd2;
  localparam logic [2:0] REG_NAME_HIGH = 3'd3;
  localparam logic [2:0] REG_NAME_TOP  = 3'd4;
  localparam logic [2:0] REG_OCC_INDEX = 3'd5;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  // Characters of the query syntax.
  localparam logic [7:0] CHAR_PCT   = 8'h25;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_AMP   = 8'h26;
  localparam logic [7:0] CHAR_EQ    = 8'h3D;
  localparam logic [7:0] CHAR_W     = 8'h57;
  localparam logic [7:0] CHAR_SPACE = 8'h20;

  // One input byte causes at most this many result items.
  localparam int MAX_RES = 4;
  localparam int RES_CNT_W = 3;

  // Result queue sizing: room for the results of the byte in the input stage plus one more byte.
  localparam int FIFO_DEPTH = 16;
  localparam int FIFO_AW    = 4;

  typedef struct packed {
    logic       run_last;
    logic       found;
    logic       item_kind;
    logic [7:0] out_byte;
  } result_t;

  typedef struct packed {
    logic [RES_CNT_W-1:0]      count;
    result_t [MAX_RES-1:0]     items;
  } step_t;

endpackage

`default_nettype wire

[rtl/query_param_extractor.sv]
// An accepted request passes through the scan's input register and the result queue to m_*.
// Throughput: one query byte per cycle while the result queue has room; each byte yields
// zero to four result items, and the single output port drains one item per cycle from a
// 16-entry result queue while m_tready is high.
// Reset (rst, synchronous, active high) clears the configuration registers, the scan
// state and the result queue; s_tready stays low while rst is high, and requests are
// taken from the first edge at which rst is sampled low.
`default_nettype none

module query_param_extractor import qpe_pkg::*; #(
  parameter int MAX_NAME_BYTES = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  // Query byte stream.
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  input  wire logic [7:0]            s_tdata,   // [7:0] query_byte
  input  wire logic                  s_tlast,   // end_of_query
  // Result stream.
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  output logic [7:0]                 m_tdata,   // [7:0] out_byte
  output logic [1:0]                 m_tuser,   // [0] item_kind, [1] found
  output logic                       m_tlast,   // run_last
  // Configuration writes.
  input  wire logic                  cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  // A request moves into the scan's input register when the result queue has
  // room for both the byte already there and this one. The scan logic then
  // compares the byte with the configured name, tracks the phase of the
  // current segment and decodes value bytes, producing up to four results
  // that are all written into the queue at the next edge.

  logic    s_fire;
  step_t   step;
  result_t head;
  logic    room;

  assign s_fire   = s_tvalid && s_tready;
  // No request is taken while reset holds the input register empty.
  assign s_tready = room && !rst;

  qpe_scan #(
    .MAX_NAME_BYTES(MAX_NAME_BYTES)
  ) u_scan (
    .clk       (clk),
    .rst       (rst),
    .in_fire   (s_fire),
    .in_byte_d (s_tdata),
    .in_last_d (s_tlast),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .step      (step)
  );

  // The queue separates the scan from the output handshake, so a stalled
  // consumer does not stop new requests until the queue nears full.
  qpe_res_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .wr         (step),
    .head       (head),
    .head_valid (m_tvalid),
    .head_ready (m_tready),
    .room       (room)
  );

  assign m_tdata = head.out_byte;
  assign m_tuser = {head.found, head.item_kind};
  assign m_tlast = head.run_last;

`ifndef SYNTH
  // The final byte of a query always produces at least the status item.
  a_last_reports: assert property (@(posedge clk) disable iff (rst)
    s_fire && s_tlast |=> step.count != 3'd0)
    else $error("no result for the final byte of a query");

  // The last result written for a byte carries run_last.
  a_run_last: assert property (@(posedge clk) disable iff (rst)
    step.count != 3'd0 |-> step.items[2'(step.count - 3'd1)].run_last)
    else $error("last result of a byte lacks run_last");

  // A status item is always the last result of its byte.
  a_status_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tlast)
    else $error("status item not marked last");
`endif

endmodule

`default_nettype wire

[rtl/qpe_scan.sv]
`default_nettype none

module qpe_scan import qpe_pkg::*; #(
  parameter int MAX_NAME_BYTES = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_fire,
  input  wire logic [7:0]            in_byte_d,
  input  wire logic                  in_last_d,
  input  wire logic                  cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  output step_t                      step
);

  localparam int PW = $clog2(MAX_NAME_BYTES + 1);
  localparam int IW = (MAX_NAME_BYTES > 1) ? $clog2(MAX_NAME_BYTES) : 1;

  localparam logic [1:0] PH_MATCH = 2'd0;
  localparam logic [1:0] PH_SKIP  = 2'd1;
  localparam logic [1:0] PH_VALUE = 2'd2;
  localparam logic [1:0] PH_DONE  = 2'd3;

  function automatic logic [7:0] lower_ascii(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
           (c >= 8'h41 && c <= 8'h46);
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [7:0] l;
    l = lower_ascii(c);
    return (l >= 8'h30 && l <= 8'h39) ? 4'(l - 8'h30) : 4'(l - CHAR_W);
  endfunction

  // Configuration registers.
  logic [5:0] name_length;
  logic [7:0] name_b [MAX_NAME_BYTES];
  logic [7:0] occ_index;

  // Input stage.
  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_last;

  // Scan state.
  logic [1:0]    phase, phase_next;
  logic [PW-1:0] pos, pos_next;
  logic [7:0]    occ_left, occ_left_next;
  logic          found_flag, found_next;
  logic [1:0]    pcnt, pcnt_next;
  logic [7:0]    pend1, pend1_next;

  logic [PW-1:0] eff_len;

  assign eff_len = (name_length > 6'(MAX_NAME_BYTES)) ? PW'(MAX_NAME_BYTES)
                                                       : PW'(name_length);

  always_ff @(posedge clk) begin
    if (rst) begin
      name_length <= '0;
      occ_index   <= '0;
      for (int j = 0; j < MAX_NAME_BYTES; j++) begin
        name_b[j] <= '0;
      end
    end else if (cfg_wr_en) begin
      if (cfg_index == REG_NAME_LEN) begin
        name_length <= cfg_data[5:0];
      end
      if (cfg_index == REG_OCC_INDEX) begin
        occ_index <= cfg_data[7:0];
      end
      for (int j = 0; j < MAX_NAME_BYTES; j++) begin
        if (cfg_index == REG_NAME_LO + 3'(j >> 3)) begin
          name_b[j] <= cfg_data[(j & 7) * 8 +: 8];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    in_byte <= in_byte_d;
    in_last <= in_last_d;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= in_fire;
    end
  end

  always_comb begin
    logic [2:0]  n;
    logic        fresh;
    result_t [MAX_RES-1:0] res;
    n             = '0;
    fresh         = 1'b1;
    res           = '0;
    phase_next    = phase;
    pos_next      = pos;
    occ_left_next = occ_left;
    found_next    = found_flag;
    pcnt_next     = pcnt;
    pend1_next    = pend1;

    unique case (phase)
      PH_MATCH: begin
        if (in_byte == CHAR_AMP) begin
          pos_next = '0;
        end else if (pos < eff_len) begin
          if (lower_ascii(in_byte) == lower_ascii(name_b[pos[IW-1:0]])) begin
            pos_next = pos + PW'(1);
          end else begin
            phase_next = PH_SKIP;
          end
        end else if (in_byte == CHAR_EQ) begin
          if (occ_left == 8'd0) begin
            phase_next = PH_VALUE;
            found_next = 1'b1;
            pcnt_next  = 2'd0;
          end else begin
            occ_left_next = occ_left - 8'd1;
            phase_next    = PH_SKIP;
          end
        end else begin
          phase_next = PH_SKIP;
        end
      end
      PH_SKIP: begin
        if (in_byte == CHAR_AMP) begin
          phase_next = PH_MATCH;
          pos_next   = '0;
        end
      end
      PH_VALUE: begin
        if (pcnt == 2'd1) begin
          if (is_hex(in_byte)) begin
            pend1_next = in_byte;
            pcnt_next  = 2'd2;
            fresh      = 1'b0;
          end else begin
            res[n[1:0]] = '{run_last: 1'b0, found: 1'b0, item_kind: 1'b0, out_byte: CHAR_PCT};
            n = n + 3'd1;
            pcnt_next = 2'd0;
          end
        end else if (pcnt == 2'd2) begin
          if (is_hex(in_byte)) begin
            res[n[1:0]] = '{run_last: 1'b0, found: 1'b0, item_kind: 1'b0,
                            out_byte: {hex_val(pend1), hex_val(in_byte)}};
            n = n + 3'd1;
            pcnt_next = 2'd0;
            fresh     = 1'b0;
          end else begin
            res[n[1:0]] = '{run_last: 1'b0, found: 1'b0, item_kind: 1'b0, out_byte: CHAR_PCT};
            n = n + 3'd1;
            res[n[1:0]] = '{run_last: 1'b0, found: 1'b0, item_kind: 1'b0, out_byte: pend1};
            n = n + 3'd1;
            pcnt_next = 2'd0;
          end
        end
        if (fresh) begin
          if (in_byte == CHAR_PCT) begin
            pcnt_next = 2'd1;
          end else if (in_byte == CHAR_AMP) begin
            phase_next = PH_DONE;
          end else if (in_byte == CHAR_PLUS) begin
            res[n[1:0]] = '{run_last: 1'b0, found: 1'b0, item_kind: 1'b0, out_byte: CHAR_SPACE};
            n = n + 3'd1;
          end else begin
            res[n[1:0]] = '{run_last: 1'b0, found: 1'b0, item_kind: 1'b0, out_byte: in_byte};
            n = n + 3'd1;
          end
        end
      end
      PH_DONE: begin
      end
      default: begin
      end
    endcase

    if (in_last) begin
      // Flush any held escape bytes, report, and restart the scan.
      if (pcnt_next != 2'd0) begin
        res[n[1:0]] = '{run_last: 1'b0, found: 1'b0, item_kind: 1'b0, out_byte: CHAR_PCT};
        n = n + 3'd1;
      end
      if (pcnt_next == 2'd2) begin
        res[n[1:0]] = '{run_last: 1'b0, found: 1'b0, item_kind: 1'b0, out_byte: pend1_next};
        n = n + 3'd1;
      end
      res[n[1:0]] = '{run_last: 1'b0, found: found_next, item_kind: 1'b1, out_byte: 8'd0};
      n = n + 3'd1;
      phase_next    = PH_MATCH;
      pos_next      = '0;
      occ_left_next = occ_index;
      found_next    = 1'b0;
      pcnt_next     = 2'd0;
    end

    for (int k = 0; k < MAX_RES; k++) begin
      res[k].run_last = (3'(k) + 3'd1 == n);
    end

    step.items = res;
    step.count = in_valid ? n : 3'd0;
  end

  always_ff @(posedge clk) begin
    if (in_valid) begin
      pend1 <= pend1_next;
    end
    if (rst) begin
      phase      <= PH_MATCH;
      pos        <= '0;
      occ_left   <= '0;
      found_flag <= 1'b0;
      pcnt       <= 2'd0;
    end else begin
      if (in_valid) begin
        phase      <= phase_next;
        pos        <= pos_next;
        found_flag <= found_next;
        pcnt       <= pcnt_next;
      end
      if (cfg_wr_en && cfg_index == REG_OCC_INDEX) begin
        occ_left <= cfg_data[7:0];
      end else if (in_valid) begin
        occ_left <= occ_left_next;
      end
    end
  end

endmodule

`default_nettype wire

[rtl/qpe_res_fifo.sv]
`default_nettype none

module qpe_res_fifo import qpe_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  step_t     wr,
  output result_t   head,
  output logic      head_valid,
  input  wire logic head_ready,
  output logic      room
);

  result_t mem [FIFO_DEPTH];

  logic [FIFO_AW-1:0] wr_ptr;
  logic [FIFO_AW-1:0] rd_ptr;
  logic [FIFO_AW:0]   cnt;
  logic               pop;

  assign head_valid = (cnt != '0);
  assign head       = mem[rd_ptr];
  assign pop        = head_valid && head_ready;

  // Keep space for a full burst from the input stage and one from a new request.
  assign room = (cnt <= (FIFO_AW+1)'(FIFO_DEPTH - 2 * MAX_RES));

  always_ff @(posedge clk) begin
    for (int k = 0; k < MAX_RES; k++) begin
      if (RES_CNT_W'(k) < wr.count) begin
        mem[wr_ptr + FIFO_AW'(k)] <= wr.items[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      wr_ptr <= wr_ptr + FIFO_AW'(wr.count);
      if (pop) begin
        rd_ptr <= rd_ptr + FIFO_AW'(1);
      end
      cnt <= cnt + (FIFO_AW+1)'(wr.count) - (FIFO_AW+1)'(pop);
    end
  end

endmodule

`default_nettype wire

[tb/sv/query_param_extractor_test.sv]
`timescale 1ns / 1ps

module query_param_extractor_test;
  import qpe_pkg::*;

  localparam int NAME_MAX = 32;
  localparam int CLK_PERIOD = 20;
  localparam int LIMIT_CYCLES = 200000;
  localparam int HOLD_CYCLES = 300;
  localparam int RANDOM_BYTES = 225;
  localparam int MAX_REPORTS = 40;
  localparam int IDLE_PCT = 12;
  localparam int SETTLE_CYCLES = 4;

  localparam string ALNUM = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789-_.";
  localparam string HEX_CHARS = "0123456789abcdefABCDEF";

  typedef enum logic [1:0] {
    SCAN_NAME,
    SCAN_SKIP,
    SCAN_VALUE,
    SCAN_DONE
  } scan_phase_e;

  // One row of the directed part: either a register write or one query byte.
  // A row marked typed carries its single result here instead of asking the predictor.
  typedef struct {
    logic                  is_cfg;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
    logic                  last;
    logic                  typed;
    result_t               want;
  } plan_row_t;

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [7:0]            s_tdata;   // [7:0] query_byte
  logic                  s_tlast;   // end_of_query
  logic                  m_tvalid;
  logic                  m_tready;
  logic [7:0]            m_tdata;   // [7:0] out_byte
  logic [1:0]            m_tuser;   // [0] item_kind, [1] found
  logic                  m_tlast;   // run_last
  logic                  cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  query_param_extractor #(
    .MAX_NAME_BYTES(NAME_MAX)
  ) dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tlast(s_tlast),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser),
    .m_tlast(m_tlast),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // Our own copy of the configuration and of the scanner state.
  logic [5:0]  name_len_r;
  logic [63:0] name_word [4];
  logic [7:0]  occ_index_r;
  scan_phase_e phase;
  logic [5:0]  name_pos;
  logic [7:0]  occ_left;
  logic        found_r;
  logic [1:0]  esc_cnt;
  logic [7:0]  esc_byte [2];

  result_t   byte_results [$];   // results caused by the most recent query byte
  result_t   due_results [$];    // results predicted but not yet seen on the output
  plan_row_t plan_q [$];
  logic [7:0] query_q [$];

  int  accepted_cnt = 0;
  int  error_cnt = 0;
  bit  held_off = 1'b0;

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // Hard stop in case the block hangs on a handshake.
  initial begin
    #(LIMIT_CYCLES * CLK_PERIOD);
    $display("FAIL");
    $finish;
  end

  task automatic report_mismatch(input string what);
    error_cnt++;
    if (error_cnt <= MAX_REPORTS) $display("mismatch at %0t ns: %s", $time, what);
  endtask

  // Both sides stop idling while a window of the random part goes by, so the
  // block also sees long stretches of back-to-back traffic.
  function automatic int idle_pct();
    return (accepted_cnt >= 150 && accepted_cnt < 210) ? 0 : IDLE_PCT;
  endfunction

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
  endfunction

  function automatic logic is_hex_digit(input logic [7:0] c);
    return (c >= "0" && c <= "9") || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
  endfunction

  function automatic logic [3:0] hex_nibble(input logic [7:0] c);
    logic [7:0] l;
    l = to_lower(c);
    // Letters map through 'W' so that 'a' lands on ten.
    return (l >= "0" && l <= "9") ? 4'(l - "0") : 4'(l - CHAR_W);
  endfunction

  function automatic void add_result(input logic kind, input logic [7:0] b, input logic f);
    result_t r;
    r.out_byte  = b;
    r.item_kind = kind;
    r.found     = f;
    r.run_last  = 1'b0;
    byte_results.insert(byte_results.size(), r);
  endfunction

  function automatic void restart_scan();
    phase       = SCAN_NAME;
    name_pos    = '0;
    occ_left    = occ_index_r;
    found_r     = 1'b0;
    esc_cnt     = '0;
    esc_byte[0] = '0;
    esc_byte[1] = '0;
  endfunction

  function automatic int eff_name_len();
    return (name_len_r > NAME_MAX) ? NAME_MAX : int'(name_len_r);
  endfunction

  function automatic logic [7:0] name_char(input int i);
    return name_word[i / 8][(i % 8) * 8 +: 8];
  endfunction

  // Advances the scanner by one query byte and leaves its results in byte_results.
  function automatic void decode_query_byte(input logic [7:0] b, input logic last);
    logic take_fresh;
    byte_results.delete();
    case (phase)
      SCAN_NAME: begin
        // An ampersand always opens a new segment, even in the middle of the name.
        if (b == CHAR_AMP) begin
          name_pos = '0;
        end else if (name_pos < eff_name_len()) begin
          if (to_lower(b) == to_lower(name_char(int'(name_pos)))) name_pos++;
          else phase = SCAN_SKIP;
        end else if (b == CHAR_EQ) begin
          if (occ_left == 0) begin
            phase   = SCAN_VALUE;
            found_r = 1'b1;
            esc_cnt = '0;
          end else begin
            occ_left--;
            phase = SCAN_SKIP;
          end
        end else begin
          phase = SCAN_SKIP;
        end
      end
      SCAN_SKIP: begin
        if (b == CHAR_AMP) begin
          phase    = SCAN_NAME;
          name_pos = '0;
        end
      end
      SCAN_VALUE: begin
        take_fresh = 1'b1;
        // A held escape either absorbs this byte as a hex digit or is released raw.
        if (esc_cnt == 2'd1) begin
          if (is_hex_digit(b)) begin
            esc_byte[1] = b;
            esc_cnt     = 2'd2;
            take_fresh  = 1'b0;
          end else begin
            add_result(1'b0, esc_byte[0], 1'b0);
            esc_cnt = '0;
          end
        end else if (esc_cnt == 2'd2) begin
          if (is_hex_digit(b)) begin
            add_result(1'b0, {hex_nibble(esc_byte[1]), hex_nibble(b)}, 1'b0);
            esc_cnt    = '0;
            take_fresh = 1'b0;
          end else begin
            add_result(1'b0, esc_byte[0], 1'b0);
            add_result(1'b0, esc_byte[1], 1'b0);
            esc_cnt = '0;
          end
        end
        if (take_fresh) begin
          if (b == CHAR_PCT) begin
            esc_byte[0] = b;
            esc_cnt     = 2'd1;
          end else if (b == CHAR_AMP) begin
            phase = SCAN_DONE;
          end else if (b == CHAR_PLUS) begin
            add_result(1'b0, CHAR_SPACE, 1'b0);
          end else begin
            add_result(1'b0, b, 1'b0);
          end
        end
      end
      default: ;
    endcase

    // End of query: flush an unfinished escape, report, and start over.
    if (last) begin
      if (esc_cnt >= 2'd1) add_result(1'b0, esc_byte[0], 1'b0);
      if (esc_cnt >= 2'd2) add_result(1'b0, esc_byte[1], 1'b0);
      add_result(1'b1, 8'h00, found_r);
      restart_scan();
    end

    if (byte_results.size() > 0) byte_results[byte_results.size() - 1].run_last = 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // Offers one query byte, waits for the handshake and records what it should cause.
  task automatic send_byte(input logic [7:0] b, input logic last, input logic typed,
                           input result_t want);
    while ($urandom_range(99) < idle_pct()) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
    accepted_cnt++;
    decode_query_byte(b, last);
    if (typed) begin
      due_results.insert(due_results.size(), want);
    end else begin
      foreach (byte_results[i]) due_results.insert(due_results.size(), byte_results[i]);
    end
  endtask

  // Waits until every predicted result has come out, then lets the pipeline
  // settle, since a byte that causes nothing may still be inside the block.
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    case (idx)
      REG_NAME_LEN:  name_len_r = data[5:0];
      REG_NAME_LO:   name_word[0] = data;
      REG_NAME_MID:  name_word[1] = data;
      REG_NAME_HIGH: name_word[2] = data;
      REG_NAME_TOP:  name_word[3] = data;
      REG_OCC_INDEX: begin
        // The occurrence counter reloads at once on this write.
        occ_index_r = data[7:0];
        occ_left    = data[7:0];
      end
      default: ;
    endcase
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Directed table helpers
  // ---------------------------------------------------------------------------

  function automatic void cfg_row(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
    plan_row_t r;
    r = '{is_cfg: 1'b1, idx: idx, data: data, last: 1'b0, typed: 1'b0, want: '0};
    plan_q.insert(plan_q.size(), r);
  endfunction

  function automatic void byte_row(input logic [7:0] b, input logic last, input logic typed,
                                   input result_t want);
    plan_row_t r;
    r = '{is_cfg: 1'b0, idx: '0, data: {56'd0, b}, last: last, typed: typed, want: want};
    plan_q.insert(plan_q.size(), r);
  endfunction

  // Each character of the text becomes one row; the last one may close the query.
  function automatic void text_rows(input string s, input logic close_query);
    for (int i = 0; i < s.len(); i++) byte_row(s[i], close_query && (i == s.len() - 1), 1'b0, '0);
  endfunction

  // ---------------------------------------------------------------------------
  // Random query generation
  // ---------------------------------------------------------------------------

  function automatic void add_query_char(input logic [7:0] c);
    query_q.insert(query_q.size(), c);
  endfunction

  function automatic logic [7:0] rand_pick(input string s);
    return s[$urandom_range(s.len() - 1)];
  endfunction

  function automatic logic [7:0] flip_case(input logic [7:0] c);
    logic is_letter;
    is_letter = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    return (is_letter && $urandom_range(1)) ? (c ^ 8'h20) : c;
  endfunction

  // Names are mostly plain words, with the odd separator or arbitrary byte mixed in.
  function automatic logic [7:0] rand_name_char();
    case ($urandom_range(19))
      0: return CHAR_AMP;
      1: return CHAR_EQ;
      2: return 8'($urandom_range(255));
      default: return rand_pick(ALNUM);
    endcase
  endfunction

  task automatic push_value();
    int n;
    int r;
    n = $urandom_range(6);
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 45) begin
        add_query_char(rand_pick(ALNUM));
      end else if (r < 60) begin
        add_query_char(CHAR_PLUS);
      end else if (r < 82) begin
        // Percent escapes: mostly complete, sometimes cut short by a non-hex byte.
        add_query_char(CHAR_PCT);
        case ($urandom_range(9))
          0, 1, 2, 3, 4, 5, 6: begin
            add_query_char(rand_pick(HEX_CHARS));
            add_query_char(rand_pick(HEX_CHARS));
          end
          7: begin
            add_query_char(rand_pick(HEX_CHARS));
            add_query_char("g" + 8'($urandom_range(19)));
          end
          8: add_query_char(CHAR_PCT);
          default: ;
        endcase
      end else begin
        add_query_char(8'($urandom_range(255)));
      end
    end
  endtask

  task automatic push_name(input logic corrupt);
    int len;
    int at;
    len = eff_name_len();
    at = query_q.size();
    for (int i = 0; i < len; i++) add_query_char(flip_case(name_char(i)));
    if (corrupt && len > 0) query_q[at + $urandom_range(len - 1)] = rand_pick(ALNUM);
  endtask

  // Builds one query, mostly well-formed segments around the configured name.
  task automatic build_query();
    int nseg;
    int kind;
    int n;
    query_q.delete();
    nseg = $urandom_range(1, 4);
    if ($urandom_range(9) == 0) add_query_char(CHAR_AMP);
    for (int s = 0; s < nseg; s++) begin
      if (s > 0) add_query_char(CHAR_AMP);
      kind = $urandom_range(9);
      if (kind <= 5) begin
        push_name($urandom_range(7) == 0);
        add_query_char(CHAR_EQ);
        push_value();
      end else if (kind <= 7) begin
        n = $urandom_range(4);
        for (int i = 0; i < n; i++) add_query_char(rand_pick(ALNUM));
        add_query_char(CHAR_EQ);
        push_value();
      end else if (kind == 8) begin
        push_name(1'b0);
        add_query_char(rand_pick(ALNUM));
        push_value();
      end else begin
        n = $urandom_range(1, 4);
        for (int i = 0; i < n; i++) add_query_char(8'($urandom_range(255)));
      end
    end
    if ($urandom_range(9) == 0) add_query_char(CHAR_AMP);
  endtask

  // Picks a fresh setting and writes every register; the block must be idle.
  task automatic choose_settings();
    int len;
    logic [7:0] occ;
    logic [63:0] words [4];
    logic [CFG_DATA_W-1:0] data;
    case ($urandom_range(15))
      0: len = 0;
      1: len = NAME_MAX;
      2: len = 63;
      3: len = $urandom_range(NAME_MAX + 1, 62);
      default: len = $urandom_range(1, 5);
    endcase
    case ($urandom_range(9))
      0: occ = 8'hFF;
      1: occ = 8'd2;
      default: occ = 8'($urandom_range(1));
    endcase
    for (int i = 0; i < NAME_MAX; i++) begin
      words[i / 8][(i % 8) * 8 +: 8] = (i < len) ? rand_name_char() : 8'($urandom_range(255));
    end
    // Bits above the register width carry noise that the block must ignore.
    data = {$urandom(), $urandom()};
    data[5:0] = len[5:0];
    write_reg(REG_NAME_LEN, data);
    write_reg(REG_NAME_LO, words[0]);
    write_reg(REG_NAME_MID, words[1]);
    write_reg(REG_NAME_HIGH, words[2]);
    write_reg(REG_NAME_TOP, words[3]);
    data = {$urandom(), $urandom()};
    data[7:0] = occ;
    write_reg(REG_OCC_INDEX, data);
  endtask

  // ---------------------------------------------------------------------------
  // Result sink: random back-pressure plus one long hold-off that fills the
  // result queue and forces the block to stall its input.
  // ---------------------------------------------------------------------------

  initial begin
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!held_off && accepted_cnt >= 90) begin
        held_off = 1'b1;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      m_tready <= ($urandom_range(99) >= idle_pct());
    end
  end

  always @(posedge clk) begin : check_results
    result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (due_results.size() == 0) begin
        report_mismatch($sformatf("result byte %02h user %b last %b with nothing due",
                                  m_tdata, m_tuser, m_tlast));
      end else begin
        want = due_results.pop_front();
        if (m_tdata !== want.out_byte)
          report_mismatch($sformatf("out_byte %02h, wanted %02h", m_tdata, want.out_byte));
        if (m_tuser[0] !== want.item_kind)
          report_mismatch($sformatf("item_kind %b, wanted %b", m_tuser[0], want.item_kind));
        if (m_tuser[1] !== want.found)
          report_mismatch($sformatf("found %b, wanted %b", m_tuser[1], want.found));
        if (m_tlast !== want.run_last)
          report_mismatch($sformatf("run_last %b, wanted %b", m_tlast, want.run_last));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------

  initial begin
    int directed_cnt;
    rst       <= 1'b1;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    s_tlast   <= 1'b0;
    cfg_wr_en <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;

    name_len_r  = '0;
    occ_index_r = '0;
    foreach (name_word[i]) name_word[i] = '0;
    restart_scan();

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Right after reset the name is empty: a lone zero byte that ends the
    // query is not a match, so only a not-found report comes out.
    byte_row(8'h00, 1'b1, 1'b1,
             result_t'{run_last: 1'b1, found: 1'b0, item_kind: 1'b1, out_byte: 8'h00});
    // With an empty name a segment that opens with '=' matches at once.
    text_rows("=", 1'b0);
    byte_row(8'hFF, 1'b1, 1'b0, '0);
    // Name "Id", second occurrence: case-blind compare, skipping the first match,
    // a full escape, a plus, a broken escape, and an ampersand ending the value.
    cfg_row(REG_NAME_LEN, 64'd2);
    cfg_row(REG_NAME_LO, {48'd0, "dI"});
    cfg_row(REG_OCC_INDEX, 64'd1);
    text_rows("iD=1&id=%4a+%z&", 1'b1);
    // First occurrence with a half-finished escape flushed at the end of the query.
    cfg_row(REG_OCC_INDEX, 64'd0);
    text_rows("id=%4", 1'b1);
    // Empty value at the end of the query gives only a found report.
    text_rows("id", 1'b0);
    byte_row(CHAR_EQ, 1'b1, 1'b1,
             result_t'{run_last: 1'b1, found: 1'b1, item_kind: 1'b1, out_byte: 8'h00});

    foreach (plan_q[i]) begin
      if (plan_q[i].is_cfg) begin
        wait_idle();
        write_reg(plan_q[i].idx, plan_q[i].data);
      end else begin
        send_byte(plan_q[i].data[7:0], plan_q[i].last, plan_q[i].typed, plan_q[i].want);
      end
    end
    directed_cnt = accepted_cnt;

    // Random phases: a new setting, then a few queries under it.
    while (accepted_cnt < directed_cnt + RANDOM_BYTES) begin
      wait_idle();
      choose_settings();
      repeat ($urandom_range(1, 3)) begin
        build_query();
        foreach (query_q[i]) send_byte(query_q[i], i == query_q.size() - 1, 1'b0, '0);
      end
    end

    wait_idle();
    repeat (8) @(posedge clk);
    if (error_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

[query_param_extractor.f]
rtl/qpe_pkg.sv
rtl/qpe_scan.sv
rtl/qpe_res_fifo.sv
rtl/query_param_extractor.sv
tb/sv/query_param_extractor_test.sv
